[hw/rtl/paf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// paf_pkg: shared types and constants of the planar array factor block
// Field widths, fixed-point constants, CORDIC arctangent table and sequencer
// states.
// ----------------------------------------------------------------------------
package paf_pkg;

    localparam int MAX_COLUMNS_DEF = 16;
    localparam int MAX_ROWS_DEF    = 32;

    localparam int ANG_W   = 16;   // Q3.13 angle
    localparam int PITCH_W = 16;   // Q8.8 length
    localparam int OUT_W   = 16;   // Q1.15 result
    localparam int COLS_W  = 5;
    localparam int ROWS_W  = 6;
    localparam int TURN_W  = 32;   // Q0.32 turns
    localparam int CW      = 33;   // CORDIC datapath, Q2.30 plus guard
    localparam int MW      = 34;   // multiplier operand
    localparam int PW      = 2 * MW;
    localparam int DVW     = 50;   // divider dividend
    localparam int DSW     = 16;   // divider divisor
    localparam int SW      = DVW;  // grid sum accumulators
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEPS   = 16;
    localparam int STEP_W  = 4;
    localparam int Q30     = 30;
    localparam int OUT_SH  = 45;

    localparam logic [COLS_W-1:0]  COLS_RST  = 5'd8;
    localparam logic [ROWS_W-1:0]  ROWS_RST  = 6'd16;
    localparam logic [PITCH_W-1:0] CPITCH_RST = 16'd512;
    localparam logic [PITCH_W-1:0] RPITCH_RST = 16'd512;
    localparam logic [PITCH_W-1:0] WAVE_RST   = 16'd256;

    // 2^32 / (2*pi) scaled by 2^3 for Q3.13 in, 2^16 dropped after multiply
    localparam logic signed [MW-1:0] RAD_TO_TURNS = 34'sd5468522205;
    localparam logic signed [CW-1:0] CORDIC_GAIN  = 33'sd652032874;
    localparam logic signed [CW-1:0] QUARTER      = 33'sd1073741824;
    localparam logic signed [CW-1:0] HALF         = 33'sd2147483648;

    typedef enum logic [2:0] {
        CFG_COLS   = 3'd0,
        CFG_ROWS   = 3'd1,
        CFG_CPITCH = 3'd2,
        CFG_RPITCH = 3'd3,
        CFG_WAVE   = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_AZ,
        ST_COR_AZ,
        ST_WAIT_AZ,
        ST_MUL_EL,
        ST_COR_EL,
        ST_WAIT_EL,
        ST_MUL_P,
        ST_MUL_HA,
        ST_DIV_HA,
        ST_WAIT_HA,
        ST_MUL_HB,
        ST_DIV_HB,
        ST_WAIT_HB,
        ST_MUL_CS,
        ST_MUL_RS,
        ST_INIT,
        ST_ELEM,
        ST_EWAIT,
        ST_MUL_N,
        ST_DIV_RE,
        ST_WAIT_RE,
        ST_DIV_IM,
        ST_WAIT_IM,
        ST_MUL_G,
        ST_MUL_OR,
        ST_MUL_OI,
        ST_OUT
    } t_state;

    // arctangent of 2^-i in Q0.32 turns
    function automatic logic [TURN_W-1:0] atan_turns(input logic [STEP_W-1:0] i);
        logic [TURN_W-1:0] v;
        unique case (i)
            4'd0:  v = 32'h20000000;
            4'd1:  v = 32'h12E4051E;
            4'd2:  v = 32'h09FB385B;
            4'd3:  v = 32'h051111D4;
            4'd4:  v = 32'h028B0D43;
            4'd5:  v = 32'h0145D7E1;
            4'd6:  v = 32'h00A2F61E;
            4'd7:  v = 32'h00517C55;
            4'd8:  v = 32'h0028BE53;
            4'd9:  v = 32'h00145F2F;
            4'd10: v = 32'h000A2F98;
            4'd11: v = 32'h000517CC;
            4'd12: v = 32'h00028BE6;
            4'd13: v = 32'h000145F3;
            4'd14: v = 32'h0000A2FA;
            default: v = 32'h0000517D;
        endcase
        return v;
    endfunction

    // round (add half of 2^45), floor shift, saturate to Q1.15
    function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [PW-1:0] v);
        logic signed [PW-1:0]        t;
        logic signed [PW-OUT_SH-1:0] q;
        logic signed [OUT_W-1:0]     r;
        t = v + (PW'(1) <<< (OUT_SH - 1));
        q = t[PW-1:OUT_SH];
        if (q > (PW-OUT_SH)'(32767)) begin
            r = 16'sh7FFF;
        end else if (q < -(PW-OUT_SH)'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/paf_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// paf_cordic: iterative rotation CORDIC
// Turns in Q0.32 to cosine and sine in Q2.30, one rotation per cycle.
// ----------------------------------------------------------------------------
module paf_cordic (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [paf_pkg::TURN_W-1:0]       i_turns,
    output logic                                  o_done,
    output logic signed [paf_pkg::CW-1:0]         o_cos,
    output logic signed [paf_pkg::CW-1:0]         o_sin
);

    logic signed [paf_pkg::CW-1:0] r_x, r_y, r_z;
    logic signed [paf_pkg::CW-1:0] w_z0, w_xs, w_ys, w_at;
    logic [paf_pkg::STEP_W-1:0]    r_i;
    logic                          r_busy, r_neg, w_neg0;

    // fold into the right half plane, negate at the end
    always_comb begin
        w_z0   = paf_pkg::CW'($signed(i_turns));
        w_neg0 = 1'b0;
        if (w_z0 > paf_pkg::QUARTER) begin
            w_z0   = w_z0 - paf_pkg::HALF;
            w_neg0 = 1'b1;
        end else if (w_z0 < -paf_pkg::QUARTER) begin
            w_z0   = w_z0 + paf_pkg::HALF;
            w_neg0 = 1'b1;
        end
    end

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = $signed(paf_pkg::CW'(paf_pkg::atan_turns(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_i    <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == paf_pkg::STEP_W'(paf_pkg::STEPS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= paf_pkg::CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= w_z0;
            r_neg <= w_neg0;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_cos = r_neg ? -r_x : r_x;
    assign o_sin = r_neg ? -r_y : r_y;

endmodule
`default_nettype wire

[hw/rtl/paf_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// paf_div: bit-serial divider
// Signed dividend by unsigned nonzero divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module paf_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [paf_pkg::DVW-1:0]    i_dividend,
    input  wire logic [paf_pkg::DSW-1:0]           i_divisor,
    output logic                                   o_done,
    output logic signed [paf_pkg::DVW-1:0]         o_quotient
);

    localparam int CNT_W = $clog2(paf_pkg::DVW + 1);

    logic [paf_pkg::DVW-1:0] r_q;
    logic [paf_pkg::DSW-1:0] r_rem, r_dsr;
    logic [paf_pkg::DSW:0]   w_sh, w_diff;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy, r_neg, w_bit;

    assign w_sh   = {r_rem, r_q[paf_pkg::DVW-1]};
    assign w_diff = w_sh - {1'b0, r_dsr};
    assign w_bit  = (w_sh >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(paf_pkg::DVW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[paf_pkg::DVW-1] ? -i_dividend : i_dividend;
            r_neg <= i_dividend[paf_pkg::DVW-1];
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[paf_pkg::DSW-1:0] : w_sh[paf_pkg::DSW-1:0];
            r_q   <= {r_q[paf_pkg::DVW-2:0], w_bit};
        end
    end

    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule
`default_nettype wire

[hw/rtl/planar_array_factor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// planar_array_factor: normalized array factor of a uniform planar grid
// For a grid of C columns and R rows, each of the C*R emitters takes its turn on
// the shared CORDIC, and each of the four divisions runs on the bit-serial
// divider. One item at a time: a new start is taken only while idle.
// The result strobe is high for one cycle; the receiver cannot stall.
// Synchronous active-low reset restores the control and config registers.
// ----------------------------------------------------------------------------
module planar_array_factor #(
    parameter int MAX_COLUMNS = paf_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = paf_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic signed [paf_pkg::ANG_W-1:0]      i_azimuth,
    input  wire logic signed [paf_pkg::ANG_W-1:0]      i_elevation,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [paf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [paf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                       o_valid,
    output logic signed [paf_pkg::OUT_W-1:0]           o_factor_real,
    output logic signed [paf_pkg::OUT_W-1:0]           o_factor_imag
);

    localparam int CC_W = $clog2(MAX_COLUMNS + 1);
    localparam int RC_W = $clog2(MAX_ROWS + 1);
    localparam int MW   = paf_pkg::MW;
    localparam int PW   = paf_pkg::PW;
    localparam int CW   = paf_pkg::CW;

    paf_pkg::t_state r_state, n_state;

    logic [paf_pkg::COLS_W-1:0]  r_cfg_cols;
    logic [paf_pkg::ROWS_W-1:0]  r_cfg_rows;
    logic [paf_pkg::PITCH_W-1:0] r_cfg_cpitch, r_cfg_rpitch, r_cfg_wave;

    logic signed [paf_pkg::ANG_W-1:0] r_az, r_el;
    logic [CC_W-1:0] r_cols, r_l, w_cols;
    logic [RC_W-1:0] r_rows, r_m, w_rows;
    logic [paf_pkg::DSW-1:0] r_w, r_n;
    logic signed [CW-1:0] r_ca, r_sa, r_ce, r_se, r_sre, r_sim, r_g;
    logic [paf_pkg::TURN_W-1:0] r_ha, r_hb, r_col0, r_col, r_row;
    logic signed [paf_pkg::SW-1:0] r_sum_re, r_sum_im;
    logic signed [paf_pkg::OUT_W-1:0] r_ore;

    logic signed [MW-1:0] w_mul_a, w_mul_b;
    logic signed [PW-1:0] r_prod;
    logic signed [CW-1:0] w_prod_q30;

    logic                          w_cor_start, w_cor_done;
    logic [paf_pkg::TURN_W-1:0]    w_cor_turns;
    logic signed [CW-1:0]          w_cor_cos, w_cor_sin;
    logic                          w_div_start, w_div_done;
    logic signed [paf_pkg::DVW-1:0] w_div_dividend, w_div_q;
    logic [paf_pkg::DSW-1:0]       w_div_divisor;
    logic                          w_last_col, w_last_row;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != paf_pkg::ST_IDLE);
    assign w_prod_q30  = r_prod[CW+paf_pkg::Q30-1:paf_pkg::Q30];
    assign w_last_col  = (r_l == r_cols - 1'b1);
    assign w_last_row  = (r_m == r_rows - 1'b1);

    // clamp the counts to the grid that the hardware supports
    always_comb begin
        if (r_cfg_cols == '0) begin
            w_cols = CC_W'(1);
        end else if (int'(r_cfg_cols) > MAX_COLUMNS) begin
            w_cols = CC_W'(MAX_COLUMNS);
        end else begin
            w_cols = CC_W'(r_cfg_cols);
        end
        if (r_cfg_rows == '0) begin
            w_rows = RC_W'(1);
        end else if (int'(r_cfg_rows) > MAX_ROWS) begin
            w_rows = RC_W'(MAX_ROWS);
        end else begin
            w_rows = RC_W'(r_cfg_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols   <= paf_pkg::COLS_RST;
            r_cfg_rows   <= paf_pkg::ROWS_RST;
            r_cfg_cpitch <= paf_pkg::CPITCH_RST;
            r_cfg_rpitch <= paf_pkg::RPITCH_RST;
            r_cfg_wave   <= paf_pkg::WAVE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                paf_pkg::CFG_COLS:   r_cfg_cols   <= i_cfg_data[paf_pkg::COLS_W-1:0];
                paf_pkg::CFG_ROWS:   r_cfg_rows   <= i_cfg_data[paf_pkg::ROWS_W-1:0];
                paf_pkg::CFG_CPITCH: r_cfg_cpitch <= i_cfg_data;
                paf_pkg::CFG_RPITCH: r_cfg_rpitch <= i_cfg_data;
                paf_pkg::CFG_WAVE:   r_cfg_wave   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier, product registered every cycle
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            paf_pkg::ST_MUL_AZ: begin
                w_mul_a = MW'(r_az);
                w_mul_b = paf_pkg::RAD_TO_TURNS;
            end
            paf_pkg::ST_MUL_EL: begin
                w_mul_a = MW'(r_el);
                w_mul_b = paf_pkg::RAD_TO_TURNS;
            end
            paf_pkg::ST_MUL_P: begin
                w_mul_a = MW'(r_ce);
                w_mul_b = MW'(r_sa);
            end
            paf_pkg::ST_MUL_HA: begin
                w_mul_a = $signed(MW'({r_cfg_cpitch, 1'b0}));
                w_mul_b = MW'(w_prod_q30);
            end
            paf_pkg::ST_MUL_HB: begin
                w_mul_a = $signed(MW'({r_cfg_rpitch, 1'b0}));
                w_mul_b = MW'(r_se);
            end
            paf_pkg::ST_MUL_CS: begin
                w_mul_a = $signed(MW'(r_ha));
                w_mul_b = $signed(MW'(r_cols - 1'b1));
            end
            paf_pkg::ST_MUL_RS: begin
                w_mul_a = $signed(MW'(r_hb));
                w_mul_b = $signed(MW'(r_rows - 1'b1));
            end
            paf_pkg::ST_MUL_N: begin
                w_mul_a = $signed(MW'(r_cols));
                w_mul_b = $signed(MW'(r_rows));
            end
            paf_pkg::ST_MUL_G: begin
                w_mul_a = MW'(r_ce);
                w_mul_b = MW'(r_ca);
            end
            paf_pkg::ST_MUL_OR: begin
                w_mul_a = MW'(r_sre);
                w_mul_b = MW'(w_prod_q30);
            end
            paf_pkg::ST_MUL_OI: begin
                w_mul_a = MW'(r_sim);
                w_mul_b = MW'(r_g);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= paf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        w_cor_start    = 1'b0;
        w_cor_turns    = r_row + r_col;
        w_div_start    = 1'b0;
        w_div_dividend = r_prod[paf_pkg::DVW-1:0];
        w_div_divisor  = r_w;
        unique case (r_state)
            paf_pkg::ST_IDLE:    if (i_start) n_state = paf_pkg::ST_MUL_AZ;
            paf_pkg::ST_MUL_AZ:  n_state = paf_pkg::ST_COR_AZ;
            paf_pkg::ST_COR_AZ: begin
                w_cor_start = 1'b1;
                w_cor_turns = r_prod[paf_pkg::TURN_W+15:16];
                n_state     = paf_pkg::ST_WAIT_AZ;
            end
            paf_pkg::ST_WAIT_AZ: if (w_cor_done) n_state = paf_pkg::ST_MUL_EL;
            paf_pkg::ST_MUL_EL:  n_state = paf_pkg::ST_COR_EL;
            paf_pkg::ST_COR_EL: begin
                w_cor_start = 1'b1;
                w_cor_turns = r_prod[paf_pkg::TURN_W+15:16];
                n_state     = paf_pkg::ST_WAIT_EL;
            end
            paf_pkg::ST_WAIT_EL: if (w_cor_done) n_state = paf_pkg::ST_MUL_P;
            paf_pkg::ST_MUL_P:   n_state = paf_pkg::ST_MUL_HA;
            paf_pkg::ST_MUL_HA:  n_state = paf_pkg::ST_DIV_HA;
            paf_pkg::ST_DIV_HA: begin
                w_div_start = 1'b1;
                n_state     = paf_pkg::ST_WAIT_HA;
            end
            paf_pkg::ST_WAIT_HA: if (w_div_done) n_state = paf_pkg::ST_MUL_HB;
            paf_pkg::ST_MUL_HB:  n_state = paf_pkg::ST_DIV_HB;
            paf_pkg::ST_DIV_HB: begin
                w_div_start = 1'b1;
                n_state     = paf_pkg::ST_WAIT_HB;
            end
            paf_pkg::ST_WAIT_HB: if (w_div_done) n_state = paf_pkg::ST_MUL_CS;
            paf_pkg::ST_MUL_CS:  n_state = paf_pkg::ST_MUL_RS;
            paf_pkg::ST_MUL_RS:  n_state = paf_pkg::ST_INIT;
            paf_pkg::ST_INIT:    n_state = paf_pkg::ST_ELEM;
            paf_pkg::ST_ELEM: begin
                w_cor_start = 1'b1;
                n_state     = paf_pkg::ST_EWAIT;
            end
            paf_pkg::ST_EWAIT: begin
                if (w_cor_done) begin
                    n_state = (w_last_col && w_last_row) ? paf_pkg::ST_MUL_N
                                                         : paf_pkg::ST_ELEM;
                end
            end
            paf_pkg::ST_MUL_N:   n_state = paf_pkg::ST_DIV_RE;
            paf_pkg::ST_DIV_RE: begin
                w_div_start    = 1'b1;
                w_div_dividend = r_sum_re;
                w_div_divisor  = r_prod[paf_pkg::DSW-1:0];
                n_state        = paf_pkg::ST_WAIT_RE;
            end
            paf_pkg::ST_WAIT_RE: if (w_div_done) n_state = paf_pkg::ST_DIV_IM;
            paf_pkg::ST_DIV_IM: begin
                w_div_start    = 1'b1;
                w_div_dividend = r_sum_im;
                w_div_divisor  = r_n;
                n_state        = paf_pkg::ST_WAIT_IM;
            end
            paf_pkg::ST_WAIT_IM: if (w_div_done) n_state = paf_pkg::ST_MUL_G;
            paf_pkg::ST_MUL_G:   n_state = paf_pkg::ST_MUL_OR;
            paf_pkg::ST_MUL_OR:  n_state = paf_pkg::ST_MUL_OI;
            paf_pkg::ST_MUL_OI:  n_state = paf_pkg::ST_OUT;
            paf_pkg::ST_OUT:     n_state = paf_pkg::ST_IDLE;
            default:             n_state = paf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == paf_pkg::ST_OUT);
        end
    end

    // datapath registers, loaded by sequencer state
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            paf_pkg::ST_IDLE: begin
                if (i_start) begin
                    r_az   <= i_azimuth;
                    r_el   <= i_elevation;
                    r_cols <= w_cols;
                    r_rows <= w_rows;
                    r_w    <= (r_cfg_wave == '0) ? paf_pkg::DSW'(1) : r_cfg_wave;
                end
            end
            paf_pkg::ST_WAIT_AZ: begin
                r_ca <= w_cor_cos;
                r_sa <= w_cor_sin;
            end
            paf_pkg::ST_WAIT_EL: begin
                r_ce <= w_cor_cos;
                r_se <= w_cor_sin;
            end
            paf_pkg::ST_WAIT_HA: r_ha <= w_div_q[paf_pkg::TURN_W-1:0];
            paf_pkg::ST_WAIT_HB: r_hb <= w_div_q[paf_pkg::TURN_W-1:0];
            paf_pkg::ST_MUL_RS:  r_col0 <= -r_prod[paf_pkg::TURN_W-1:0];
            paf_pkg::ST_INIT: begin
                r_row    <= -r_prod[paf_pkg::TURN_W-1:0];
                r_col    <= r_col0;
                r_l      <= '0;
                r_m      <= '0;
                r_sum_re <= '0;
                r_sum_im <= '0;
            end
            paf_pkg::ST_EWAIT: begin
                if (w_cor_done) begin
                    r_sum_re <= r_sum_re + paf_pkg::SW'(w_cor_cos);
                    r_sum_im <= r_sum_im + paf_pkg::SW'(w_cor_sin);
                    // advance along the row, wrap to the next row
                    if (w_last_col) begin
                        r_l   <= '0;
                        r_col <= r_col0;
                        r_m   <= r_m + 1'b1;
                        r_row <= r_row + {r_hb[paf_pkg::TURN_W-2:0], 1'b0};
                    end else begin
                        r_l   <= r_l + 1'b1;
                        r_col <= r_col + {r_ha[paf_pkg::TURN_W-2:0], 1'b0};
                    end
                end
            end
            paf_pkg::ST_DIV_RE:  r_n <= r_prod[paf_pkg::DSW-1:0];
            paf_pkg::ST_WAIT_RE: r_sre <= w_div_q[CW-1:0];
            paf_pkg::ST_WAIT_IM: r_sim <= w_div_q[CW-1:0];
            paf_pkg::ST_MUL_OR:  r_g <= w_prod_q30;
            paf_pkg::ST_MUL_OI:  r_ore <= paf_pkg::to_q15(r_prod);
            paf_pkg::ST_OUT: begin
                o_factor_real <= r_ore;
                o_factor_imag <= paf_pkg::to_q15(r_prod);
            end
            default: ;
        endcase
    end

    paf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_turns (w_cor_turns),
        .o_done  (w_cor_done),
        .o_cos   (w_cor_cos),
        .o_sin   (w_cor_sin)
    );

    paf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

endmodule
`default_nettype wire
